@@ rtl/core/clb_pkg.sv @@
// clb_pkg: shared types, character codes and scan modes of the comment and literal blanker
// used by clb_scan, clb_outq and c_comment_literal_blanker_top; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package clb_pkg;

   // result queue depth, at least 2 (one request may push two results)
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      MODE_TEXT    = 3'd0,
      MODE_BLOCK   = 3'd1,
      MODE_LINE    = 3'd2,
      MODE_STR     = 3'd3,
      MODE_STR_ESC = 3'd4,
      MODE_CHR     = 3'd5,
      MODE_CHR_ESC = 3'd6
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } entry_type;

   // results of one request: count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      entry_type  first;
      entry_type  second;
   } push_type;

endpackage

`default_nettype wire

@@ rtl/core/clb_scan.sv @@
// clb_scan: scan mode and lookahead byte registers with the per-byte blanking logic
// depends on clb_pkg
`timescale 1ns / 1ps
`default_nettype none

module clb_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output clb_pkg::push_type      push
);
   import clb_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic       done;
   logic       pre_valid;
   logic [7:0] pre_byte;
   logic       main_valid;
   logic [7:0] main_byte;

   // release of a held byte, and whether it finishes the step
   always_comb begin
      pre_valid = held_valid_ff;
      pre_byte  = held_byte_ff;
      done      = 1'b0;
      if (held_valid_ff) begin
         if (mode_ff == MODE_BLOCK) begin
            if (in_byte == CH_SLASH) begin
               pre_byte = CH_STAR;
               done     = 1'b1;
            end else begin
               pre_byte = CH_SPACE;
            end
         end else if (in_byte == CH_STAR || in_byte == CH_SLASH) begin
            done = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      mode_in       = mode_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      if (fire) begin
         held_valid_in = 1'b0;
         if (held_valid_ff && done) begin
            if (mode_ff == MODE_BLOCK) begin
               mode_in = MODE_TEXT;
            end else if (in_byte == CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               mode_in = MODE_LINE;
            end
         end
         if (!done) begin
            case (mode_ff)
               MODE_BLOCK: begin
                  if (in_byte == CH_STAR && !in_last) begin
                     held_valid_in = 1'b1;
                     held_byte_in  = in_byte;
                  end
               end
               MODE_LINE: begin
                  if (in_byte == CH_NL) mode_in = MODE_TEXT;
               end
               MODE_STR: begin
                  if (in_byte == CH_DQUOTE) begin
                     mode_in = MODE_TEXT;
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = MODE_STR_ESC;
                  end
               end
               MODE_STR_ESC: mode_in = MODE_STR;
               MODE_CHR: begin
                  if (in_byte == CH_SQUOTE) begin
                     mode_in = MODE_TEXT;
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = MODE_CHR_ESC;
                  end
               end
               MODE_CHR_ESC: mode_in = MODE_CHR;
               default: begin
                  mode_in = MODE_TEXT;
                  if (in_byte == CH_SLASH && !in_last) begin
                     held_valid_in = 1'b1;
                     held_byte_in  = in_byte;
                  end else if (in_byte == CH_DQUOTE) begin
                     mode_in = MODE_STR;
                  end else if (in_byte == CH_SQUOTE) begin
                     mode_in = MODE_CHR;
                  end
               end
            endcase
         end
         // end of buffer puts the scanner back to its reset state
         if (in_last) begin
            mode_in       = MODE_TEXT;
            held_valid_in = 1'b0;
            held_byte_in  = 8'h00;
         end
      end
   end

   // outputs
   always_comb begin
      main_valid = 1'b0;
      main_byte  = CH_SPACE;
      if (done) begin
         main_valid = 1'b1;
         main_byte  = in_byte;
      end else begin
         case (mode_ff)
            MODE_BLOCK: begin
               if (!(in_byte == CH_STAR && !in_last)) begin
                  main_valid = 1'b1;
                  main_byte  = (in_byte == CH_NL || in_last) ? in_byte : CH_SPACE;
               end
            end
            MODE_LINE: begin
               main_valid = 1'b1;
               main_byte  = (in_byte == CH_NL) ? in_byte : CH_SPACE;
            end
            MODE_STR: begin
               main_valid = 1'b1;
               main_byte  = (in_byte == CH_DQUOTE || in_byte == CH_BSLASH ||
                             in_byte == CH_NL) ? in_byte : CH_SPACE;
            end
            MODE_STR_ESC: begin
               main_valid = 1'b1;
               main_byte  = (in_byte == CH_NL) ? in_byte : CH_SPACE;
            end
            MODE_CHR: begin
               main_valid = 1'b1;
               main_byte  = (in_byte == CH_SQUOTE || in_byte == CH_BSLASH) ?
                            in_byte : CH_SPACE;
            end
            MODE_CHR_ESC: begin
               main_valid = 1'b1;
               main_byte  = CH_SPACE;
            end
            default: begin
               if (!(in_byte == CH_SLASH && !in_last)) begin
                  main_valid = 1'b1;
                  main_byte  = in_byte;
               end
            end
         endcase
      end

      push.count       = fire ? ({1'b0, pre_valid} + {1'b0, main_valid}) : 2'd0;
      push.first.data  = pre_valid ? pre_byte : main_byte;
      push.first.last  = in_last && !(pre_valid && main_valid);
      push.second.data = main_byte;
      push.second.last = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TEXT;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'h00;
      end else begin
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/clb_outq.sv @@
// clb_outq: small result queue, two pushes and one pop per cycle
// depends on clb_pkg
`timescale 1ns / 1ps
`default_nettype none

module clb_outq #(
   parameter int DEPTH = clb_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clb_pkg::push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output clb_pkg::entry_type     out_entry
);
   import clb_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     wr_next;
   logic              pop;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + AW'(1);
      end
      return r;
   endfunction

   assign wr_next   = wrap_inc(wr_ptr_ff);
   assign out_valid = (count_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // space for a two-result request, from registered count only
   assign room      = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = wrap_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) slot_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) slot_ff[wr_next]   <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/c_comment_literal_blanker_top.sv @@
// c_comment_literal_blanker_top: top level of the comment and literal blanker
// depends on clb_pkg, clb_scan and clb_outq
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                                    moves
// req       in         req_valid req_stall req_in_byte req_in_last   one source byte
// rsp       out        rsp_valid rsp_stall rsp_out_byte rsp_out_last one output byte
//
// the scanner decides a request's zero, one or two output bytes
// combinationally and writes them into the result queue at the accepting edge
// sustained rate is one request a cycle while req_stall is low; a request releasing
// a held '/' or '*' with its own byte queues two bytes for the single-byte output port
// req_stall rises when the queue cannot take two more results (registered count)
// synchronous reset empties the queue and returns the scanner to text mode

module c_comment_literal_blanker_top #(
   parameter int QUEUE_DEPTH = clb_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);
   import clb_pkg::*;

   logic      room;
   logic      fire;
   push_type  push;
   entry_type head;

   // a request is taken whenever the queue has space for two results
   assign req_stall = !room;
   assign fire      = req_valid && room;

   // mode tracking and blanking, one byte per accepted request
   clb_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .push    (push)
   );

   // result registers, parting the request side from the response side
   clb_outq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_entry (head)
   );

   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;

endmodule

`default_nettype wire

@@ rtl/core/clb_checker.sv @@
// clb_checker: port-level assertions on the blanker top level, with its bind
// depends on c_comment_literal_blanker_top
`timescale 1ns / 1ps
`default_nettype none

module clb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last
);

   // reset leaves nothing to deliver
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // results appear only for accepted requests
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !(req_valid && !req_stall)) |=> !rsp_valid)
      else $error("response without request");

   // an empty queue always has room
   a_empty_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while queue empty");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last)))
      else $error("stalled response changed");

endmodule

bind c_comment_literal_blanker_top clb_checker u_clb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

`default_nettype wire

@@ tb/sv/clb_blank_checker.sv @@
// clb_blank_checker: watches both channels of the comment and literal blanker, predicts
// every output byte and compares; depends on clb_pkg
`timescale 1ns / 1ps

module clb_blank_checker
   import clb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_out_last,
   output int              fail_count,
   output int              expected_count
);

   mode_type   scan_state = MODE_TEXT;
   logic [7:0] held_char = 8'h00;
   logic       held_flag = 1'b0;
   entry_type  expected_bytes[$];
   entry_type  oldest;
   int         fails = 0;
   int         waiting = 0;

   assign fail_count     = fails;
   assign expected_count = waiting;

   // one line per mismatch, printing capped so a broken block cannot flood the log
   task report_mismatch(input string what);
      if (fails < 100) begin
         $display("%0t: %s", $time, what);
      end
      fails++;
   endtask

   // works out the output bytes of one request and queues them
   task predict_blanking(input logic [7:0] b, input logic fin);
      logic [7:0] outs [2];
      int         n;
      int         i;
      logic       done;
      entry_type  e;
      n    = 0;
      done = 1'b0;
      outs[0] = CH_SPACE;
      outs[1] = CH_SPACE;
      if (held_flag) begin
         held_flag = 1'b0;
         if (scan_state == MODE_BLOCK) begin
            if (b == CH_SLASH) begin
               outs[0]    = CH_STAR;
               outs[1]    = CH_SLASH;
               n          = 2;
               scan_state = MODE_TEXT;
               done       = 1'b1;
            end else begin
               outs[0] = CH_SPACE;
               n       = 1;
            end
         end else begin
            outs[0] = held_char;
            n       = 1;
            if (b == CH_STAR) begin
               outs[1]    = b;
               n          = 2;
               scan_state = MODE_BLOCK;
               done       = 1'b1;
            end else if (b == CH_SLASH) begin
               outs[1]    = b;
               n          = 2;
               scan_state = MODE_LINE;
               done       = 1'b1;
            end
         end
      end
      if (!done) begin
         case (scan_state)
            MODE_BLOCK: begin
               if (b == CH_STAR && !fin) begin
                  held_char = b;
                  held_flag = 1'b1;
               end else begin
                  outs[n] = (b == CH_NL || fin) ? b : CH_SPACE;
                  n++;
               end
            end
            MODE_LINE: begin
               if (b == CH_NL) begin
                  outs[n]    = b;
                  scan_state = MODE_TEXT;
               end else begin
                  outs[n] = CH_SPACE;
               end
               n++;
            end
            MODE_STR: begin
               if (b == CH_DQUOTE) begin
                  outs[n]    = b;
                  scan_state = MODE_TEXT;
               end else if (b == CH_BSLASH) begin
                  outs[n]    = b;
                  scan_state = MODE_STR_ESC;
               end else begin
                  outs[n] = (b == CH_NL) ? b : CH_SPACE;
               end
               n++;
            end
            MODE_STR_ESC: begin
               outs[n]    = (b == CH_NL) ? b : CH_SPACE;
               n++;
               scan_state = MODE_STR;
            end
            MODE_CHR: begin
               if (b == CH_SQUOTE) begin
                  outs[n]    = b;
                  scan_state = MODE_TEXT;
               end else if (b == CH_BSLASH) begin
                  outs[n]    = b;
                  scan_state = MODE_CHR_ESC;
               end else begin
                  outs[n] = CH_SPACE;
               end
               n++;
            end
            MODE_CHR_ESC: begin
               outs[n]    = CH_SPACE;
               n++;
               scan_state = MODE_CHR;
            end
            default: begin
               scan_state = MODE_TEXT;
               if (b == CH_SLASH && !fin) begin
                  held_char = b;
                  held_flag = 1'b1;
               end else begin
                  outs[n] = b;
                  n++;
                  if (b == CH_DQUOTE) begin
                     scan_state = MODE_STR;
                  end else if (b == CH_SQUOTE) begin
                     scan_state = MODE_CHR;
                  end
               end
            end
         endcase
      end
      for (i = 0; i < n; i++) begin
         e.data = outs[i];
         e.last = fin && (i == n - 1);
         expected_bytes.push_back(e);
      end
      // end of buffer: scanner starts afresh in text mode
      if (fin) begin
         scan_state = MODE_TEXT;
         held_char  = 8'h00;
         held_flag  = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         scan_state = MODE_TEXT;
         held_char  = 8'h00;
         held_flag  = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected output byte %h last %b",
                                         rsp_out_byte, rsp_out_last));
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_out_byte !== oldest.data) begin
                  report_mismatch($sformatf("out_byte %h, predicted %h",
                                            rsp_out_byte, oldest.data));
               end
               if (rsp_out_last !== oldest.last) begin
                  report_mismatch($sformatf("out_last %b, predicted %b",
                                            rsp_out_last, oldest.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_blanking(req_in_byte, req_in_last);
         end
      end
      waiting <= expected_bytes.size();
   end

endmodule

@@ tb/sv/c_comment_literal_blanker_top_tb.sv @@
// c_comment_literal_blanker_top_tb: drives source text through the comment and literal
// blanker and gives the verdict; depends on clb_pkg, clb_blank_checker and the block
`timescale 1ns / 1ps

module c_comment_literal_blanker_top_tb;
   import clb_pkg::*;

   logic       clock;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte  = 8'h00;
   logic       req_in_last  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   int         fail_count;
   int         expected_count;

   // control flags and counters of the sender and the receiver
   logic       no_idle      = 1'b0;
   logic       hold_request = 1'b0;
   int         hold_cycles;
   int         sent_count   = 0;

   // bytes of the buffer being built, last flag goes on the final one
   logic [7:0] text_q[$];

   c_comment_literal_blanker_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   clb_blank_checker blank_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs or drops a byte
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, none in the quiet stretch, and one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            // long enough for the result queue to fill and stall the input
            for (hold_cycles = 0; hold_cycles < 80; hold_cycles++) begin
               @(posedge clock);
            end
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 29);
         end
      end
   end

   // one request: random idle cycles first, then offer until taken
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom);
         req_in_last <= 1'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= fin;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic send_buffer();
      int i;
      for (i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   function automatic void add_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         text_q.push_back(s[i]);
      end
   endfunction

   // content byte, biased towards the characters that change the scanner's mode
   function automatic logic [7:0] pick_char();
      case ($urandom_range(11))
         0:       return CH_SLASH;
         1:       return CH_STAR;
         2:       return CH_DQUOTE;
         3:       return CH_SQUOTE;
         4:       return CH_BSLASH;
         5:       return CH_NL;
         6, 7:    return 8'($urandom_range(255));
         default: return 8'h61 + 8'($urandom_range(25));
      endcase
   endfunction

   // one well-formed token with random content, or a bit of noise
   function automatic void add_token();
      int n;
      int i;
      n = $urandom_range(5);
      case ($urandom_range(5))
         0: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_STAR);
            for (i = 0; i < n; i++) text_q.push_back(pick_char());
            text_q.push_back(CH_STAR);
            text_q.push_back(CH_SLASH);
         end
         1: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_SLASH);
            for (i = 0; i < n; i++) text_q.push_back(pick_char());
            text_q.push_back(CH_NL);
         end
         2: begin
            text_q.push_back(CH_DQUOTE);
            for (i = 0; i < n; i++) text_q.push_back(pick_char());
            text_q.push_back(CH_DQUOTE);
         end
         3: begin
            text_q.push_back(CH_SQUOTE);
            if ($urandom_range(1) == 0) text_q.push_back(CH_BSLASH);
            text_q.push_back(pick_char());
            text_q.push_back(CH_SQUOTE);
         end
         4: begin
            for (i = 0; i <= n; i++) text_q.push_back(8'($urandom_range(255)));
         end
         default: begin
            for (i = 0; i <= n; i++) text_q.push_back(8'h61 + 8'($urandom_range(25)));
         end
      endcase
   endfunction

   // a buffer of a few tokens; about one in four is cut short so it may end mid-token
   task automatic send_random_buffers(input int upto);
      int tokens;
      int keep;
      while (sent_count < upto) begin
         text_q.delete();
         tokens = 1 + $urandom_range(5);
         repeat (tokens) add_token();
         if ($urandom_range(3) == 0 && text_q.size() > 1) begin
            keep = 1 + $urandom_range(text_q.size() - 2);
            while (text_q.size() > keep) void'(text_q.pop_back());
         end
         send_buffer();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // lone star as the final byte of a block comment stays
      add_string("/**");
      send_buffer();
      // slash then plain text, line comment ending in the top byte value
      add_string("/a//");
      text_q.push_back(8'hFF);
      send_buffer();
      // trailing backslash in a string
      add_string("\"\\");
      send_buffer();
      // escaped char literal
      add_string("'\\n'");
      send_buffer();
      // zero byte, then a newline after a backslash inside a string
      text_q.push_back(8'h00);
      add_string("\"a\\\n\"");
      send_buffer();
      // newline kept in a block comment, star held over a star, close, final slash in text
      add_string("/*\n**//");
      send_buffer();

      // random text with idling on both sides
      send_random_buffers(sent_count + 150);
      // receiver holds off while requests keep coming
      hold_request = 1'b1;
      send_random_buffers(sent_count + 100);
      // quiet stretch: no idling at all
      no_idle = 1'b1;
      send_random_buffers(sent_count + 120);
      no_idle = 1'b0;
      send_random_buffers(sent_count + 130);
      req_valid <= 1'b0;

      // drain, then give any stray byte time to show up
      @(posedge clock);
      while (expected_count != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
